/* hw/rtl/hfd_pkg.sv */
// Shared types and constants for the heartbeat failure detector.
// No dependencies; every other file in the block but hfd_ram imports this package.
package hfd_pkg;

  localparam int NODE_SLOTS_DEF = 16;
  localparam int ID_W           = 4;
  localparam int CNT_W          = 32;
  localparam int ALIVE_W        = 5;
  localparam int CFG_IDX_W      = 2;

  localparam logic [ID_W-1:0]  OWN_ID_RST   = '0;
  localparam logic [CNT_W-1:0] INTERVAL_RST = CNT_W'(1000);
  localparam logic [CNT_W-1:0] TIMEOUT_RST  = CNT_W'(3000);

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_REMOVE    = 2'd2
  } hfd_op_t;

  typedef enum logic [2:0] {
    KIND_SENT     = 3'd0,
    KIND_FAILED   = 3'd1,
    KIND_TICK     = 3'd2,
    KIND_ACCEPTED = 3'd3,
    KIND_SELF     = 3'd4,
    KIND_REMOVED  = 3'd5,
    KIND_UNKNOWN  = 3'd6
  } hfd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID   = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } hfd_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_SCAN,
    ST_DONE,
    ST_ONE
  } hfd_state_t;

  typedef struct packed {
    hfd_op_t          op;
    logic [ID_W-1:0]  node_id;
    logic [CNT_W-1:0] seq_number;
  } hfd_in_t;

  typedef struct packed {
    hfd_kind_t          kind;
    logic [ID_W-1:0]    node_id_res;
    logic [CNT_W-1:0]   seq;
    logic [CNT_W-1:0]   timestamp;
    logic               new_node;
    logic               revived;
    logic [ALIVE_W-1:0] alive_count;
    logic [CNT_W-1:0]   received_total;
    logic [CNT_W-1:0]   failures_total;
    logic               last;
  } hfd_out_t;

  typedef struct packed {
    logic [ID_W-1:0]  own_id;
    logic [CNT_W-1:0] interval;
    logic [CNT_W-1:0] timeout;
  } hfd_cfg_t;

  // Controller to output stage: at most one result offered per cycle, held until taken.
  typedef struct packed {
    logic     emit;
    hfd_out_t res;
  } hfd_emit_t;

endpackage

/* hw/rtl/hfd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module hfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* hw/rtl/hfd_ctrl.sv */
// Sequencer of the heartbeat failure detector: slot flags, counters and the
// tick scan over the slot RAM. Depends on hfd_pkg; drives the hfd_ram ports.
module hfd_ctrl #(
  parameter int NODE_SLOTS = hfd_pkg::NODE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  hfd_pkg::hfd_in_t              in_data,
  output logic                          in_stall,
  input  hfd_pkg::hfd_cfg_t             cfg,
  input  logic                          take,
  output hfd_pkg::hfd_emit_t            emit_o,
  output logic [$clog2(NODE_SLOTS)-1:0] ram_raddr,
  input  logic [2*hfd_pkg::CNT_W-1:0]   ram_rdata,
  output logic                          ram_we,
  output logic [$clog2(NODE_SLOTS)-1:0] ram_waddr,
  output logic [2*hfd_pkg::CNT_W-1:0]   ram_wdata
);
  import hfd_pkg::*;

  localparam int SW = $clog2(NODE_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(NODE_SLOTS - 1);

  hfd_state_t         state_r, state_nxt;
  hfd_in_t            in_r, in_nxt;
  logic [CNT_W-1:0]   time_r, time_nxt;
  logic [CNT_W-1:0]   last_sent_r, last_sent_nxt;
  logic [CNT_W-1:0]   own_seq_r, own_seq_nxt;
  logic [CNT_W-1:0]   recv_r, recv_nxt;
  logic [CNT_W-1:0]   fail_r, fail_nxt;
  logic [NODE_SLOTS-1:0] known_r, known_nxt;
  logic [NODE_SLOTS-1:0] alive_r, alive_nxt;
  logic [ALIVE_W-1:0] alive_cnt_r, alive_cnt_nxt;
  logic [SW-1:0]      idx_r, idx_nxt;

  logic [SW-1:0]      id_idx;
  logic               id_in_range;
  logic [CNT_W-1:0]   rd_seen;
  logic [CNT_W-1:0]   rd_seq;
  logic               expired;
  logic               advance;

  assign id_idx      = SW'(in_r.node_id);
  assign id_in_range = 32'(in_r.node_id) < NODE_SLOTS;
  assign rd_seen     = ram_rdata[2*CNT_W-1:CNT_W];
  assign rd_seq      = ram_rdata[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      last_sent_r <= '0;
      own_seq_r   <= '0;
      recv_r      <= '0;
      fail_r      <= '0;
      known_r     <= '0;
      alive_r     <= '0;
      alive_cnt_r <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      last_sent_r <= last_sent_nxt;
      own_seq_r   <= own_seq_nxt;
      recv_r      <= recv_nxt;
      fail_r      <= fail_nxt;
      known_r     <= known_nxt;
      alive_r     <= alive_nxt;
      alive_cnt_r <= alive_cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    time_nxt      = time_r;
    last_sent_nxt = last_sent_r;
    own_seq_nxt   = own_seq_r;
    recv_nxt      = recv_r;
    fail_nxt      = fail_r;
    known_nxt     = known_r;
    alive_nxt     = alive_r;
    alive_cnt_nxt = alive_cnt_r;
    idx_nxt       = idx_r;

    in_stall  = (state_r != ST_IDLE);
    ram_raddr = id_idx;
    ram_we    = 1'b0;
    ram_waddr = id_idx;
    ram_wdata = {time_r, in_r.seq_number};
    expired   = 1'b0;
    advance   = 1'b0;

    emit_o                    = '0;
    emit_o.res.kind           = KIND_UNKNOWN;
    emit_o.res.timestamp      = time_r;
    emit_o.res.alive_count    = alive_cnt_r;
    emit_o.res.received_total = recv_r;
    emit_o.res.failures_total = fail_r;

    case (state_r)
      ST_IDLE: begin
        ram_raddr = SW'(in_data.node_id);
        if (in_valid) begin
          in_nxt = in_data;
          if (in_data.op == OP_TICK) begin
            time_nxt  = time_r + 1'b1;
            state_nxt = ST_SEND;
          end else begin
            state_nxt = ST_ONE;
          end
        end
      end

      ST_SEND: begin
        // prefetch slot 0 for the scan
        ram_raddr = '0;
        idx_nxt   = '0;
        if ((time_r - last_sent_r) >= cfg.interval) begin
          emit_o.emit            = 1'b1;
          emit_o.res.kind        = KIND_SENT;
          emit_o.res.node_id_res = cfg.own_id;
          emit_o.res.seq         = own_seq_r + 1'b1;
          if (take) begin
            own_seq_nxt   = own_seq_r + 1'b1;
            last_sent_nxt = time_r;
            state_nxt     = ST_SCAN;
          end
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        expired = known_r[idx_r] && alive_r[idx_r] && ((time_r - rd_seen) >= cfg.timeout);
        advance = !expired || take;
        if (expired) begin
          emit_o.emit               = 1'b1;
          emit_o.res.kind           = KIND_FAILED;
          emit_o.res.node_id_res    = ID_W'(idx_r);
          emit_o.res.seq            = rd_seq;
          emit_o.res.failures_total = fail_r + 1'b1;
          emit_o.res.alive_count    = alive_cnt_r - 1'b1;
          if (take) begin
            alive_nxt[idx_r] = 1'b0;
            fail_nxt         = fail_r + 1'b1;
            alive_cnt_nxt    = alive_cnt_r - 1'b1;
          end
        end
        // hold the read address while a failure waits on the output
        ram_raddr = advance ? idx_r + 1'b1 : idx_r;
        if (advance) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_DONE: begin
        emit_o.emit            = 1'b1;
        emit_o.res.kind        = KIND_TICK;
        emit_o.res.node_id_res = cfg.own_id;
        emit_o.res.seq         = own_seq_r;
        emit_o.res.last        = 1'b1;
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_ONE: begin
        emit_o.emit            = 1'b1;
        emit_o.res.last        = 1'b1;
        emit_o.res.node_id_res = in_r.node_id;
        case (in_r.op)
          OP_HEARTBEAT: begin
            if (in_r.node_id == cfg.own_id) begin
              emit_o.res.kind = KIND_SELF;
              emit_o.res.seq  = own_seq_r;
            end else if (id_in_range) begin
              emit_o.res.kind           = KIND_ACCEPTED;
              emit_o.res.seq            = in_r.seq_number;
              emit_o.res.new_node       = !known_r[id_idx];
              emit_o.res.revived        = known_r[id_idx] && !alive_r[id_idx];
              emit_o.res.received_total = recv_r + 1'b1;
              emit_o.res.alive_count    = (known_r[id_idx] && alive_r[id_idx]) ?
                                          alive_cnt_r : alive_cnt_r + 1'b1;
              if (take) begin
                ram_we            = 1'b1;
                known_nxt[id_idx] = 1'b1;
                alive_nxt[id_idx] = 1'b1;
                recv_nxt          = recv_r + 1'b1;
                alive_cnt_nxt     = emit_o.res.alive_count;
              end
            end
          end
          OP_REMOVE: begin
            if (id_in_range && known_r[id_idx]) begin
              emit_o.res.kind        = KIND_REMOVED;
              emit_o.res.seq         = rd_seq;
              emit_o.res.alive_count = alive_r[id_idx] ? alive_cnt_r - 1'b1 : alive_cnt_r;
              if (take) begin
                known_nxt[id_idx] = 1'b0;
                alive_nxt[id_idx] = 1'b0;
                alive_cnt_nxt     = emit_o.res.alive_count;
              end
            end
          end
          default: begin
            emit_o.res.kind = KIND_UNKNOWN;
          end
        endcase
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/heartbeat_failure_detector_unit.sv */
// Top level of the heartbeat failure detector: configuration registers,
// output register and slot RAM. Depends on hfd_pkg, hfd_ram and hfd_ctrl.
//
//   port group   direction   handshake            payload
//   in_*         input       in_valid / in_stall  hfd_in_t   (op, node_id, seq_number)
//   out_*        output      out_valid/out_stall  hfd_out_t  (one or more per transaction)
//   cfg_*        input       cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// Heartbeat, remove and undefined ops: accept, then one result.
// Tick: accept, send check, one slot RAM read per slot, summary; the single
// read port of the slot RAM sets the scan pace.
// out_stall holds the sequencer wherever a result cannot enter the output
// register; a new transaction is taken while the final result still waits.
// Synchronous reset clears all control state; no clearing pass is needed.
module heartbeat_failure_detector_unit #(
  parameter int NODE_SLOTS = hfd_pkg::NODE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hfd_pkg::hfd_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hfd_pkg::hfd_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hfd_pkg::CNT_W-1:0]       cfg_wdata
);
  import hfd_pkg::*;

  localparam int SW = $clog2(NODE_SLOTS);

  hfd_cfg_t          cfg_r;
  logic              out_valid_r;
  hfd_out_t          out_data_r;
  hfd_emit_t         emit;
  logic              take;
  logic [SW-1:0]     ram_raddr;
  logic [SW-1:0]     ram_waddr;
  logic              ram_we;
  logic [2*CNT_W-1:0] ram_wdata;
  logic [2*CNT_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id   <= OWN_ID_RST;
      cfg_r.interval <= INTERVAL_RST;
      cfg_r.timeout  <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (hfd_cfg_idx_t'(cfg_index))
        CFG_OWN_ID:   cfg_r.own_id   <= cfg_wdata[ID_W-1:0];
        CFG_INTERVAL: cfg_r.interval <= cfg_wdata;
        CFG_TIMEOUT:  cfg_r.timeout  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the output register takes a result when empty or being drained
  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= emit.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit.emit) begin
      out_data_r <= emit.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hfd_ctrl #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg       (cfg_r),
    .take      (take),
    .emit_o    (emit),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // per slot: {last seen time, last sequence}
  hfd_ram #(
    .WIDTH (2*CNT_W),
    .DEPTH (NODE_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule

/* hw/rtl/hfd_checker.sv */
// Port-level assertions for the heartbeat failure detector, bound to the top
// level. Depends on hfd_pkg and heartbeat_failure_detector_unit.
module hfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input hfd_pkg::hfd_out_t out_data
);
  import hfd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // sent and failed results never close a transaction
  a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_SENT || out_data.kind == KIND_FAILED)
      |-> !out_data.last)
    else $error("sent or failed result marked last");

  // every other kind closes its transaction
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_SENT && out_data.kind != KIND_FAILED
      |-> out_data.last)
    else $error("closing result not marked last");

  // only sixteen ids are addressable
  a_alive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.alive_count <= 5'd16)
    else $error("alive count out of range");

  // no transaction is taken while the sequencer is busy with a prior one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous transaction in flight");

endmodule

bind heartbeat_failure_detector_unit hfd_checker u_hfd_checker (.*);
